// ----- rtl/core/csa_pkg.sv -----
// ---------------------------------------------------------------------------
// csa_pkg: shared types and constants for the circular segment area block
// Fixed-point widths, region codes, the stage sideband struct and the
// segment fraction table, built at elaboration from a CORDIC arctangent.
// ---------------------------------------------------------------------------
package csa_pkg;

  // fixed-point formats
  localparam int FRACTION_BITS  = 16;
  localparam int TABLE_SEGMENTS = 256;
  localparam int DIAM_W         = 24;
  localparam int DEPTH_W        = 25;
  localparam int AREA_W         = 32;
  localparam int D2_W           = 2 * DIAM_W;
  localparam int QUO_W          = FRACTION_BITS + 1;
  localparam int IDX_W          = $clog2(TABLE_SEGMENTS + 1);
  localparam int POS_W          = FRACTION_BITS + IDX_W;
  localparam int FRAC_W         = 33;
  localparam int PROD_W         = FRAC_W + FRACTION_BITS + 1;
  localparam int CORDIC_STEPS   = 30;

  // pi/4 in Q0.32
  localparam logic [31:0] PI4_Q32 = 32'd3373259426;

  // rounding constant for the interpolation product
  localparam logic signed [PROD_W-1:0] ROUND_HALF =
    $signed(PROD_W'(1) << (FRACTION_BITS - 1));

  // region codes
  typedef enum logic [1:0] {
    REGION_EMPTY   = 2'd0,
    REGION_PARTIAL = 2'd1,
    REGION_FULL    = 2'd2
  } region_t;

  // fields that ride alongside the quotient through the pipeline
  typedef struct packed {
    region_t           region;
    logic [D2_W-1:0]   d2;
  } csa_side_t;

  typedef logic [31:0] seg_tab_t [0:TABLE_SEGMENTS];

  // arctangent of 2^-i in Q2.30
  localparam longint ATAN_Q30 [0:CORDIC_STEPS-1] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2
  };

  // integer square root, bit by bit
  function automatic logic [63:0] sqrt_floor(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] rem;
    r   = '0;
    rem = v;
    b   = 64'h1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 64'h0) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // segment fraction at point k of the lower half, Q0.32
  function automatic logic [31:0] lower_point(int k);
    longint c;
    longint s;
    longint x;
    longint y;
    longint z;
    longint cs;
    longint dx;
    longint dy;
    longint f;
    int     i;
    c  = (longint'(TABLE_SEGMENTS - 2 * k) << 30) / TABLE_SEGMENTS;
    s  = longint'(sqrt_floor(64'((longint'(1) << 60) - c * c)));
    x  = c;
    y  = s;
    z  = 0;
    cs = (c * s + (longint'(1) << 29)) >>> 30;
    for (i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_Q30[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_Q30[i];
      end
    end
    f = z - cs;
    if (f < 0) f = 0;
    if (f > longint'(PI4_Q32)) f = longint'(PI4_Q32);
    return f[31:0];
  endfunction

  // full table, upper half mirrored about pi/8
  function automatic seg_tab_t build_seg_table();
    seg_tab_t t;
    int       k;
    for (k = 0; k <= TABLE_SEGMENTS; k++) begin
      if (2 * k <= TABLE_SEGMENTS) begin
        t[k] = lower_point(k);
      end else begin
        t[k] = PI4_Q32 - lower_point(TABLE_SEGMENTS - k);
      end
    end
    t[0]              = '0;
    t[TABLE_SEGMENTS] = PI4_Q32;
    return t;
  endfunction

  localparam seg_tab_t SEG_TABLE = build_seg_table();

endpackage

// ----- rtl/core/circular_segment_area.sv -----
// ---------------------------------------------------------------------------
// circular_segment_area: wetted area of a circular pipe from diameter, depth
// Accepts one item/cycle while the output skid slot is free; input stalls while it is full.
// Depth set by the divider, one quotient bit per stage, plus table and scale.
// Synchronous reset empties the pipeline and the output skid buffer.
// ---------------------------------------------------------------------------
module circular_segment_area (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [csa_pkg::DIAM_W-1:0]   diameter,
  input  logic [csa_pkg::DEPTH_W-1:0]  depth,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [csa_pkg::AREA_W-1:0]   area,
  output logic [1:0]                   region
);
  import csa_pkg::*;

  // pipeline advances whenever the skid slot is free
  logic en;
  logic skid_valid;
  assign en       = !skid_valid;
  assign in_ready = en;

  // input register
  logic                s0_valid;
  logic [DIAM_W-1:0]   s0_diam;
  logic [DEPTH_W-1:0]  s0_depth;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_diam  <= diameter;
      s0_depth <= depth;
    end
  end

  // classify the depth and square the diameter
  logic       is_full;
  logic       is_empty;
  region_t    region_c;
  logic [D2_W-1:0] d2_c;

  assign is_full  = $signed(s0_depth) > $signed({1'b0, s0_diam});
  assign is_empty = s0_depth[DEPTH_W-1] || (s0_depth == '0);
  assign d2_c     = D2_W'(s0_diam) * D2_W'(s0_diam);

  always_comb begin
    priority if (is_full) begin
      region_c = REGION_FULL;
    end else if (is_empty) begin
      region_c = REGION_EMPTY;
    end else begin
      region_c = REGION_PARTIAL;
    end
  end

  logic                s1_valid;
  logic [DIAM_W-1:0]   s1_y;
  logic [DIAM_W-1:0]   s1_d;
  csa_side_t           s1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s0_valid;
    end
  end

  // outside the partial region the divider sees zero, keeping remainders bounded
  always_ff @(posedge clk) begin
    if (en) begin
      s1_y           <= (region_c == REGION_PARTIAL) ? s0_depth[DIAM_W-1:0] : '0;
      s1_d           <= s0_diam;
      s1_side.region <= region_c;
      s1_side.d2     <= d2_c;
    end
  end

  // depth ratio u
  logic              dv_valid;
  logic [QUO_W-1:0]  dv_quo;
  csa_side_t         dv_side;

  csa_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s1_valid),
    .dividend  (s1_y),
    .divisor   (s1_d),
    .in_side   (s1_side),
    .out_valid (dv_valid),
    .quotient  (dv_quo),
    .out_side  (dv_side)
  );

  // table position: index and interpolation fraction
  logic [POS_W-1:0]          pos_c;
  logic                      sa_valid;
  logic [IDX_W-1:0]          sa_idx;
  logic [FRACTION_BITS-1:0]  sa_frac;
  csa_side_t                 sa_side;

  assign pos_c = POS_W'(dv_quo) * POS_W'(TABLE_SEGMENTS);

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_valid <= 1'b0;
    end else if (en) begin
      sa_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_idx  <= pos_c[POS_W-1:FRACTION_BITS];
      sa_frac <= pos_c[FRACTION_BITS-1:0];
      sa_side <= dv_side;
    end
  end

  // table lookup of both neighbors, last point repeats at the end
  logic [IDX_W-1:0]          hi_idx;
  logic                      sb_valid;
  logic [31:0]               sb_lo;
  logic [31:0]               sb_hi;
  logic [FRACTION_BITS-1:0]  sb_frac;
  csa_side_t                 sb_side;

  assign hi_idx = (sa_idx >= IDX_W'(TABLE_SEGMENTS)) ? IDX_W'(TABLE_SEGMENTS)
                                                     : sa_idx + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_valid <= 1'b0;
    end else if (en) begin
      sb_valid <= sa_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_lo   <= SEG_TABLE[sa_idx];
      sb_hi   <= SEG_TABLE[hi_idx];
      sb_frac <= sa_frac;
      sb_side <= sa_side;
    end
  end

  // slope times fraction
  logic signed [FRAC_W-1:0]  diff_c;
  logic signed [PROD_W-1:0]  prod_c;
  logic                      sc_valid;
  logic signed [PROD_W-1:0]  sc_prod;
  logic [31:0]               sc_lo;
  csa_side_t                 sc_side;

  assign diff_c = $signed({1'b0, sb_hi}) - $signed({1'b0, sb_lo});
  assign prod_c = diff_c * $signed({1'b0, sb_frac});

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_valid <= 1'b0;
    end else if (en) begin
      sc_valid <= sb_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_prod <= prod_c;
      sc_lo   <= sb_lo;
      sc_side <= sb_side;
    end
  end

  // round, add base, clamp, then pick the fraction by region
  logic signed [PROD_W-1:0]  rnd_c;
  logic signed [PROD_W-1:0]  interp_c;
  logic [31:0]               clamp_c;
  logic [31:0]               f_c;
  logic                      sd_valid;
  logic [31:0]               sd_f;
  logic [D2_W-1:0]           sd_d2;
  region_t                   sd_region;

  assign rnd_c    = (sc_prod + ROUND_HALF) >>> FRACTION_BITS;
  assign interp_c = rnd_c + $signed(PROD_W'(sc_lo));

  always_comb begin
    priority if (interp_c < 0) begin
      clamp_c = '0;
    end else if (interp_c > $signed(PROD_W'(PI4_Q32))) begin
      clamp_c = PI4_Q32;
    end else begin
      clamp_c = interp_c[31:0];
    end
  end

  always_comb begin
    unique case (sc_side.region)
      REGION_EMPTY:   f_c = '0;
      REGION_PARTIAL: f_c = clamp_c;
      REGION_FULL:    f_c = PI4_Q32;
      default:        f_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sd_valid <= 1'b0;
    end else if (en) begin
      sd_valid <= sc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_f      <= f_c;
      sd_d2     <= sc_side.d2;
      sd_region <= sc_side.region;
    end
  end

  // scale by the squared diameter in two partial products
  logic                se_valid;
  logic [63:0]         se_p1;
  logic [47:0]         se_p0;
  region_t             se_region;

  always_ff @(posedge clk) begin
    if (rst) begin
      se_valid <= 1'b0;
    end else if (en) begin
      se_valid <= sd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      se_p1     <= 64'(sd_f) * 64'(sd_d2[31:0]);
      se_p0     <= 48'(sd_f) * 48'(sd_d2[D2_W-1:32]);
      se_region <= sd_region;
    end
  end

  // combine partial products and round to Q16.16
  logic [64:0]         p1b_c;
  logic [48:0]         sum_c;
  logic [AREA_W-1:0]   area_c;
  logic                inc_valid;

  assign p1b_c     = {1'b0, se_p1} + (65'(1) << 47);
  assign sum_c     = 49'(se_p0) + 49'(p1b_c[64:32]);
  assign area_c    = sum_c[47:16];
  assign inc_valid = se_valid && en;

  // output register with a skid slot behind it
  logic [AREA_W-1:0]   out_area;
  region_t             out_region;
  logic [AREA_W-1:0]   skid_area;
  region_t             skid_region;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      out_valid  <= skid_valid || inc_valid;
      skid_valid <= 1'b0;
    end else if (inc_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_area   <= skid_area;
        out_region <= skid_region;
      end else begin
        out_area   <= area_c;
        out_region <= se_region;
      end
    end else if (inc_valid) begin
      skid_area   <= area_c;
      skid_region <= se_region;
    end
  end

  assign area   = out_area;
  assign region = out_region;

endmodule

// ----- rtl/core/csa_div.sv -----
// ---------------------------------------------------------------------------
// csa_div: pipelined restoring divider for the depth ratio
// Forms floor(dividend * 2^FRACTION_BITS / divisor) for dividend <= divisor,
// one quotient bit per register stage, with valid and sideband alongside.
// ---------------------------------------------------------------------------
module csa_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [csa_pkg::DIAM_W-1:0]   dividend,
  input  logic [csa_pkg::DIAM_W-1:0]   divisor,
  input  csa_pkg::csa_side_t           in_side,
  output logic                         out_valid,
  output logic [csa_pkg::QUO_W-1:0]    quotient,
  output csa_pkg::csa_side_t           out_side
);
  import csa_pkg::*;

  localparam int REM_W = DIAM_W + 1;

  // index 0 is the stage input, index j+1 the register after step j
  logic                vld [0:QUO_W];
  logic [DIAM_W-1:0]   rem [0:QUO_W];
  logic [DIAM_W-1:0]   dvs [0:QUO_W];
  logic [QUO_W-1:0]    quo [0:QUO_W];
  csa_side_t           side [0:QUO_W];

  assign vld[0]  = in_valid;
  assign rem[0]  = dividend;
  assign dvs[0]  = divisor;
  assign quo[0]  = '0;
  assign side[0] = in_side;

  for (genvar j = 0; j < QUO_W; j++) begin : g_step
    logic [REM_W-1:0] shifted;
    logic [REM_W-1:0] trial;
    logic             qbit;

    // first step compares the dividend itself, later ones the doubled remainder
    assign shifted = (j == 0) ? {1'b0, rem[j]} : {rem[j], 1'b0};
    assign trial   = shifted - {1'b0, dvs[j]};
    assign qbit    = (shifted >= {1'b0, dvs[j]});

    // valid bit
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
    end

    // remainder, quotient and sideband
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1]  <= qbit ? trial[DIAM_W-1:0] : shifted[DIAM_W-1:0];
        dvs[j+1]  <= dvs[j];
        quo[j+1]  <= {quo[j][QUO_W-2:0], qbit};
        side[j+1] <= side[j];
      end
    end
  end

  assign out_valid = vld[QUO_W];
  assign quotient  = quo[QUO_W];
  assign out_side  = side[QUO_W];

endmodule
